// ===== hdl/octree_node_to_point_decoder_macros.svh =====
// Assertion macros shared by the checker of the octree point decoder.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef OCTREE_NODE_TO_POINT_DECODER_MACROS_SVH
`define OCTREE_NODE_TO_POINT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ONTP_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ontp check failed");

// The consequent must hold in the cycle after the antecedent.
`define ONTP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ontp check failed");

`endif

// ===== hdl/ontp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ontp_pkg;

   localparam int NODE_COUNT = 4096;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int COORD_W    = 32;
   localparam int LEVEL_W    = 5;
   localparam int OCC_W      = 8;
   localparam int EPOCH_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int SHIFT_W    = LEVEL_W + 1;

   localparam logic [EPOCH_W-1:0] EPOCH_CLEARED = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST   = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST    = '1;

   localparam logic ACT_NODE  = 1'b0;
   localparam logic ACT_START = 1'b1;

   localparam logic STATUS_POINT  = 1'b0;
   localparam logic STATUS_ORPHAN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TREE_LEVELS = 3'd6;

   // One node table entry. A node counts as placed when its epoch matches
   // the current tree epoch.
   typedef struct packed {
      logic [EPOCH_W-1:0]        epoch;
      logic [LEVEL_W-1:0]        level;
      logic signed [COORD_W-1:0] cz;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cx;
   } node_entry_type;

   // Arithmetic shift of a box edge, truncated to coordinate width.
   function automatic logic signed [COORD_W-1:0] edge_shift(
      input logic signed [COORD_W:0] span,
      input logic [SHIFT_W-1:0]      amount
   );
      logic signed [COORD_W:0] shifted;
      shifted = span >>> amount;
      return shifted[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ontp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ontp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // A read of the address being written returns the old word.
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== hdl/octree_node_to_point_decoder.sv =====
// Octree node to point decoder. Node records must arrive with every parent
// ahead of its children; each placed node keeps its minimum corner and level
// in a 4096-entry node table (one simple dual-port RAM, registered read).
// Internal nodes, empty leaves and start requests pass at one per cycle
// outside a clearing pass; an orphan record gives one result, and a leaf
// gives one point per set occupancy bit, so a full leaf holds the point
// emitter for all eight of its points, which sets the sustained rate.
// Placed marks are epoch tags in the table: a start request only bumps the
// epoch, but after reset and after every 255th start a clearing pass
// rewrites all 4096 table entries, and no request is taken meanwhile. Box
// spans are registered again from the configuration registers, so a
// configuration write reaches them one register after the root corners.
`timescale 1ns / 1ps
`default_nettype none

module octree_node_to_point_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_action,
   input  logic [ontp_pkg::NODE_W-1:0]              req_node_index,
   input  logic [ontp_pkg::NODE_W-1:0]              req_parent_index,
   input  logic [ontp_pkg::LEVEL_W-1:0]             req_node_level,
   input  logic [2:0]                               req_octant,
   input  logic [ontp_pkg::OCC_W-1:0]               req_occupancy,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ontp_pkg::COORD_W-1:0]      rsp_point_x,
   output logic signed [ontp_pkg::COORD_W-1:0]      rsp_point_y,
   output logic signed [ontp_pkg::COORD_W-1:0]      rsp_point_z,
   output logic                                     rsp_status,
   output logic                                     rsp_last,
   input  logic                                     csr_write_en,
   input  logic [ontp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ontp_pkg::COORD_W-1:0]             csr_wdata
);

   localparam int CW = ontp_pkg::COORD_W;
   localparam int NW = ontp_pkg::NODE_W;
   localparam int LW = ontp_pkg::LEVEL_W;
   localparam int SW = ontp_pkg::SHIFT_W;
   localparam int EW = ontp_pkg::EPOCH_W;
   localparam int OW = ontp_pkg::OCC_W;
   localparam int ENTRY_W = $bits(ontp_pkg::node_entry_type);

   // Configuration registers and the derived box edges.
   logic signed [CW-1:0] root_min_x_ff, root_min_y_ff, root_min_z_ff;
   logic signed [CW-1:0] root_max_x_ff, root_max_y_ff, root_max_z_ff;
   logic [LW-1:0]        tree_levels_ff;
   logic signed [CW:0]   span_x_ff, span_y_ff, span_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_min_x_ff  <= '0;
         root_min_y_ff  <= '0;
         root_min_z_ff  <= '0;
         root_max_x_ff  <= CW'(65536);
         root_max_y_ff  <= CW'(65536);
         root_max_z_ff  <= CW'(65536);
         tree_levels_ff <= LW'(8);
      end else if (csr_write_en) begin
         unique case (csr_index)
            ontp_pkg::CSR_ROOT_MIN_X:  root_min_x_ff  <= csr_wdata;
            ontp_pkg::CSR_ROOT_MIN_Y:  root_min_y_ff  <= csr_wdata;
            ontp_pkg::CSR_ROOT_MIN_Z:  root_min_z_ff  <= csr_wdata;
            ontp_pkg::CSR_ROOT_MAX_X:  root_max_x_ff  <= csr_wdata;
            ontp_pkg::CSR_ROOT_MAX_Y:  root_max_y_ff  <= csr_wdata;
            ontp_pkg::CSR_ROOT_MAX_Z:  root_max_z_ff  <= csr_wdata;
            ontp_pkg::CSR_TREE_LEVELS: tree_levels_ff <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      span_x_ff <= {root_max_x_ff[CW-1], root_max_x_ff} - {root_min_x_ff[CW-1], root_min_x_ff};
      span_y_ff <= {root_max_y_ff[CW-1], root_max_y_ff} - {root_min_y_ff[CW-1], root_min_y_ff};
      span_z_ff <= {root_max_z_ff[CW-1], root_max_z_ff} - {root_min_z_ff[CW-1], root_min_z_ff};
   end

   // Node table.
   logic                     ram_we;
   logic [NW-1:0]            ram_waddr;
   ontp_pkg::node_entry_type ram_wentry;
   logic [NW-1:0]            ram_raddr;
   logic [ENTRY_W-1:0]       ram_rdata;

   ontp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ontp_pkg::NODE_COUNT)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wentry),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Stage A: request waits here while its parent entry is read.
   logic          a_valid_ff;
   logic          a_action_ff;
   logic [NW-1:0] a_node_ff;
   logic [NW-1:0] a_parent_ff;
   logic [LW-1:0] a_level_ff;
   logic [2:0]    a_octant_ff;
   logic [OW-1:0] a_occ_ff;

   logic          clear_ff;
   logic [NW-1:0] clear_addr_ff;
   logic [EW-1:0] epoch_ff;

   logic                     fwd_valid_ff;
   logic [NW-1:0]            fwd_addr_ff;
   ontp_pkg::node_entry_type fwd_entry_ff;

   ontp_pkg::node_entry_type par_entry, new_entry;
   logic                     par_placed, par_leaf, a_is_root, a_is_start;
   logic                     a_orphan, a_leaf, a_job, a_go, a_write, a_wrap;
   logic [SW-1:0]            par_shift;
   logic                     req_fire, b_ready;

   always_comb begin
      // The most recent table write may not yet show in the read data.
      if (fwd_valid_ff && (fwd_addr_ff == a_parent_ff)) begin
         par_entry = fwd_entry_ff;
      end else begin
         par_entry = ontp_pkg::node_entry_type'(ram_rdata);
      end
      par_placed = (par_entry.epoch == epoch_ff);
      par_shift  = {1'b0, par_entry.level} + SW'(1);
      par_leaf   = (par_shift == {1'b0, tree_levels_ff});
      a_is_root  = (a_node_ff == '0);
      a_is_start = (a_action_ff == ontp_pkg::ACT_START);
      a_orphan   = !a_is_root && (!par_placed || par_leaf);
      a_leaf     = (({1'b0, a_level_ff} + SW'(1)) == {1'b0, tree_levels_ff});
      a_job      = !a_is_start && (a_orphan || (a_leaf && (a_occ_ff != '0)));
      a_go       = a_valid_ff && !clear_ff && (!a_job || b_ready);
      a_write    = a_go && !a_is_start && !a_orphan;
      a_wrap     = a_valid_ff && a_is_start && (epoch_ff == ontp_pkg::EPOCH_LAST);

      new_entry.epoch = epoch_ff;
      new_entry.level = a_level_ff;
      if (a_is_root) begin
         new_entry.cx = root_min_x_ff;
         new_entry.cy = root_min_y_ff;
         new_entry.cz = root_min_z_ff;
      end else begin
         new_entry.cx = par_entry.cx
            + (a_octant_ff[2] ? ontp_pkg::edge_shift(span_x_ff, par_shift) : CW'(0));
         new_entry.cy = par_entry.cy
            + (a_octant_ff[1] ? ontp_pkg::edge_shift(span_y_ff, par_shift) : CW'(0));
         new_entry.cz = par_entry.cz
            + (a_octant_ff[0] ? ontp_pkg::edge_shift(span_z_ff, par_shift) : CW'(0));
      end
   end

   assign req_ready = !clear_ff && !a_wrap && (!a_valid_ff || a_go);
   assign req_fire  = req_valid && req_ready;

   // A held request re-reads its parent every cycle.
   assign ram_raddr  = req_fire ? req_parent_index : a_parent_ff;
   assign ram_we     = clear_ff || a_write;
   assign ram_waddr  = clear_ff ? clear_addr_ff : a_node_ff;
   assign ram_wentry = clear_ff ? '0 : new_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_fire) begin
         a_valid_ff <= 1'b1;
      end else if (a_go) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_action_ff <= req_action;
         a_node_ff   <= req_node_index;
         a_parent_ff <= req_parent_index;
         a_level_ff  <= req_node_level;
         a_octant_ff <= req_octant;
         a_occ_ff    <= req_occupancy;
      end
   end

   // Epoch and clearing pass. Epoch zero marks a cleared entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= ontp_pkg::EPOCH_FIRST;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + NW'(1);
         if (clear_addr_ff == '1) begin
            clear_ff <= 1'b0;
         end
      end else if (a_go && a_is_start) begin
         if (epoch_ff == ontp_pkg::EPOCH_LAST) begin
            epoch_ff      <= ontp_pkg::EPOCH_FIRST;
            clear_ff      <= 1'b1;
            clear_addr_ff <= '0;
         end else begin
            epoch_ff <= epoch_ff + EW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (a_write) begin
         fwd_valid_ff <= 1'b1;
      end else if (a_go && a_is_start) begin
         fwd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_write) begin
         fwd_addr_ff  <= a_node_ff;
         fwd_entry_ff <= new_entry;
      end
   end

   // Stage B: leaf or orphan job; work out the point base and child step.
   logic                 b_valid_ff;
   logic                 b_orphan_ff;
   logic signed [CW-1:0] b_cx_ff, b_cy_ff, b_cz_ff;
   logic [LW-1:0]        b_level_ff;
   logic [OW-1:0]        b_occ_ff;
   logic [SW-1:0]        b_half_sh, b_quarter_sh;
   logic                 c_take;

   assign b_ready      = !b_valid_ff || c_take;
   assign b_half_sh    = {1'b0, b_level_ff} + SW'(1);
   assign b_quarter_sh = {1'b0, b_level_ff} + SW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_go && a_job;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_go && a_job) begin
         b_orphan_ff <= a_orphan;
         b_cx_ff     <= new_entry.cx;
         b_cy_ff     <= new_entry.cy;
         b_cz_ff     <= new_entry.cz;
         b_level_ff  <= a_level_ff;
         b_occ_ff    <= a_occ_ff;
      end
   end

   // Stage C: point emitter, one set occupancy bit per cycle while the output register is free, high bit first.
   logic                 c_valid_ff;
   logic                 c_orphan_ff;
   logic signed [CW-1:0] c_base_x_ff, c_base_y_ff, c_base_z_ff;
   logic signed [CW-1:0] c_half_x_ff, c_half_y_ff, c_half_z_ff;
   logic [OW-1:0]        c_occ_ff;
   logic [2:0]           c_bit;
   logic [OW-1:0]        c_occ_rest;
   logic                 c_final, out_free;
   logic signed [CW-1:0] c_point_x, c_point_y, c_point_z;

   always_comb begin
      c_bit = '0;
      for (int i = 0; i < OW; i++) begin
         if (c_occ_ff[i]) begin
            c_bit = 3'(i);
         end
      end
      c_occ_rest = c_occ_ff & ~(OW'(1) << c_bit);
      c_final    = c_orphan_ff || (c_occ_rest == '0);
      // Bit i of the occupancy is child octant 7 - i, so the octant's axis
      // bits are the inverted bits of i.
      c_point_x = c_base_x_ff + (c_bit[2] ? CW'(0) : c_half_x_ff);
      c_point_y = c_base_y_ff + (c_bit[1] ? CW'(0) : c_half_y_ff);
      c_point_z = c_base_z_ff + (c_bit[0] ? CW'(0) : c_half_z_ff);
   end

   assign out_free = !rsp_valid || rsp_ready;
   assign c_take   = !c_valid_ff || (out_free && c_final);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_take) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_take && b_valid_ff) begin
         c_orphan_ff <= b_orphan_ff;
         c_occ_ff    <= b_occ_ff;
         c_base_x_ff <= b_cx_ff + ontp_pkg::edge_shift(span_x_ff, b_quarter_sh);
         c_base_y_ff <= b_cy_ff + ontp_pkg::edge_shift(span_y_ff, b_quarter_sh);
         c_base_z_ff <= b_cz_ff + ontp_pkg::edge_shift(span_z_ff, b_quarter_sh);
         c_half_x_ff <= ontp_pkg::edge_shift(span_x_ff, b_half_sh);
         c_half_y_ff <= ontp_pkg::edge_shift(span_y_ff, b_half_sh);
         c_half_z_ff <= ontp_pkg::edge_shift(span_z_ff, b_half_sh);
      end else if (c_valid_ff && out_free) begin
         c_occ_ff <= c_occ_rest;
      end
   end

   // Output register.
   logic                 rsp_valid_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_status_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && c_valid_ff) begin
         if (c_orphan_ff) begin
            rsp_x_ff      <= '0;
            rsp_y_ff      <= '0;
            rsp_z_ff      <= '0;
            rsp_status_ff <= ontp_pkg::STATUS_ORPHAN;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_x_ff      <= c_point_x;
            rsp_y_ff      <= c_point_y;
            rsp_z_ff      <= c_point_z;
            rsp_status_ff <= ontp_pkg::STATUS_POINT;
            rsp_last_ff   <= c_final;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_point_z = rsp_z_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/ontp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "octree_node_to_point_decoder_macros.svh"

module ontp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ontp_pkg::COORD_W-1:0] rsp_point_x,
   input logic signed [ontp_pkg::COORD_W-1:0] rsp_point_y,
   input logic signed [ontp_pkg::COORD_W-1:0] rsp_point_z,
   input logic                                rsp_status,
   input logic                                rsp_last
);

   logic [3*ontp_pkg::COORD_W+1:0] rsp_word;
   logic                           rsp_no_point;

   assign rsp_word     = {rsp_point_x, rsp_point_y, rsp_point_z, rsp_status, rsp_last};
   assign rsp_no_point = (rsp_point_x == '0) && (rsp_point_y == '0) && (rsp_point_z == '0);

   // A stalled result stays offered and unchanged.
   `ONTP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `ONTP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_word))

   // A dropped record yields exactly one result, and it carries no point.
   `ONTP_ASSERT_NOW(a_orphan_last, rsp_valid && (rsp_status == ontp_pkg::STATUS_ORPHAN), rsp_last)
   `ONTP_ASSERT_NOW(a_orphan_zero, rsp_valid && (rsp_status == ontp_pkg::STATUS_ORPHAN), rsp_no_point)

endmodule

bind octree_node_to_point_decoder ontp_checker u_ontp_checker (.*);

`default_nettype wire
